// ===== hdl/gwm_pkg.sv =====
`default_nettype none

package gwm_pkg;

  // Request codes carried in req_type.
  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_NAME   = 2'd2;
  localparam logic [1:0] REQ_END    = 2'd3;

  // Wildcard bytes.
  localparam logic [7:0] STAR_BYTE = 8'h2A;
  localparam logic [7:0] ANY_BYTE  = 8'h3F;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] char_value;
  } req_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } rsp_t;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic       en;       // a transaction is accepted this cycle
    logic       restart;  // clear, append or end of name
    logic       clear;
    logic       append;
    logic [7:0] ch;
  } cell_ctrl_t;

  // What one cell hands to its right neighbor.
  typedef struct packed {
    logic head;     // set only into the first cell
    logic filled;   // this position holds a pattern byte
    logic closure;  // next activity reaches the right neighbor over a star
    logic advance;  // a byte consumed here moves activity to the right neighbor
  } cell_link_t;

endpackage

`default_nettype wire

// ===== hdl/gwm_cell.sv =====
`default_nettype none

// One pattern position: its byte, whether it is filled, and its activity bit.
module gwm_cell (
  input  wire                      clk,
  input  wire                      rst,
  input  wire gwm_pkg::cell_ctrl_t ctrl,
  input  wire gwm_pkg::cell_link_t left,
  output gwm_pkg::cell_link_t      right,
  output logic                     hit
);

  logic [7:0] pat_byte;
  logic       filled;
  logic       active;

  logic       is_star;
  logic       byte_match;
  logic       wr_en;
  logic       filled_next;
  logic [7:0] byte_next;
  logic       star_next;
  logic       active_next;
  logic       seed;

  always_comb begin
    is_star     = filled && (pat_byte == gwm_pkg::STAR_BYTE);
    byte_match  = filled && !is_star &&
                  ((pat_byte == gwm_pkg::ANY_BYTE) || (pat_byte == ctrl.ch));
    wr_en       = ctrl.append && !filled && left.filled;
    filled_next = ctrl.clear ? 1'b0 : (filled || wr_en);
    byte_next   = wr_en ? ctrl.ch : pat_byte;
    star_next   = filled_next && (byte_next == gwm_pkg::STAR_BYTE);
    // A star keeps its own activity; other bytes pass activity to the right.
    seed        = ctrl.restart ? left.head : ((active && is_star) || left.advance);
    active_next = seed || left.closure;
  end

  assign right.head    = 1'b0;
  assign right.filled  = filled;
  assign right.closure = active_next && star_next;
  assign right.advance = active && byte_match;

  // Active at the first empty position means the whole pattern was consumed.
  assign hit = active && left.filled && !filled;

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= 1'b0;
      active <= left.head;
    end else if (ctrl.en) begin
      filled <= filled_next;
      active <= active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pat_byte <= ctrl.ch;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/glob_wildcard_matcher.sv =====
// Glob wildcard matcher: '*' matches any run of bytes, '?' any single byte.
// Request channel (req_valid, req_stall, req_data): each transaction clears
// the pattern, appends one pattern byte, gives one name byte, or ends the
// name. Response channel (rsp_valid, rsp_stall, rsp_data): one transaction
// per end of name, carrying the verdict and the overflow flag.
// A request is taken in the cycle it is offered unless req_stall is high;
// the sustained rate is one request per clock while req_stall stays low.
// The pattern lives in a row of MAX_PATTERN cells; the automaton update,
// including the ripple of activity across runs of stars, is combinational.
// An end-of-name response is registered on its way to rsp_valid.
// Two response registers sit on the output; the request side stalls only
// when both hold results the receiver has not taken, so one waiting result
// never stops pattern and name traffic. A stalled response holds steady.
// Reset (synchronous, active high) empties the pattern, clears the overflow
// flag, restarts the automaton and drops any pending responses. A pattern
// byte past MAX_PATTERN is dropped and sets the overflow flag; verdicts are
// then false until the next clear.
`default_nettype none

module glob_wildcard_matcher #(
  parameter int MAX_PATTERN = 64
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 req_valid,
  output logic                req_stall,
  input  wire gwm_pkg::req_t  req_data,
  output logic                rsp_valid,
  input  wire                 rsp_stall,
  output gwm_pkg::rsp_t       rsp_data
);

  logic                 req_take;
  gwm_pkg::cell_ctrl_t  ctrl;
  gwm_pkg::cell_link_t  link [MAX_PATTERN+1];
  logic [MAX_PATTERN-1:0] hits;

  // Activity of the position past the last cell.
  logic                 end_active;
  logic                 end_active_next;
  logic                 overflow;

  logic                 verdict_hit;
  logic                 new_valid;
  gwm_pkg::rsp_t        new_rsp;

  logic                 skid_valid;
  gwm_pkg::rsp_t        skid_rsp;
  logic                 rsp_take;

  assign req_stall = skid_valid;
  assign req_take  = req_valid && !req_stall;

  always_comb begin
    ctrl.en      = req_take;
    ctrl.restart = req_take && (req_data.req_type != gwm_pkg::REQ_NAME);
    ctrl.clear   = req_take && (req_data.req_type == gwm_pkg::REQ_CLEAR);
    ctrl.append  = req_take && (req_data.req_type == gwm_pkg::REQ_APPEND);
    ctrl.ch      = req_data.char_value;
  end

  // The first cell sees a filled, seeded neighbor with no activity to hand on.
  assign link[0] = '{head: 1'b1, filled: 1'b1, closure: 1'b0, advance: 1'b0};

  genvar g;
  generate
    for (g = 0; g < MAX_PATTERN; g++) begin : g_cell
      gwm_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .ctrl  (ctrl),
        .left  (link[g]),
        .right (link[g+1]),
        .hit   (hits[g])
      );
    end
  endgenerate

  // The last position has no byte of its own; it is reached only from the
  // last cell, either by a consumed byte or across a trailing star.
  always_comb begin
    end_active_next = (ctrl.restart ? 1'b0 : link[MAX_PATTERN].advance) ||
                      link[MAX_PATTERN].closure;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      end_active <= 1'b0;
      overflow   <= 1'b0;
    end else begin
      if (req_take) begin
        end_active <= end_active_next;
      end
      if (ctrl.clear) begin
        overflow <= 1'b0;
      end else if (ctrl.append && link[MAX_PATTERN].filled) begin
        overflow <= 1'b1;
      end
    end
  end

  // The verdict reads the state before this request's restart.
  always_comb begin
    verdict_hit              = (|hits) || (end_active && link[MAX_PATTERN].filled);
    new_valid                = req_take && (req_data.req_type == gwm_pkg::REQ_END);
    new_rsp.matched          = verdict_hit && !overflow;
    new_rsp.pattern_overflow = overflow;
  end

  // Output register plus one skid entry.
  assign rsp_take = rsp_valid && !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!rsp_valid || rsp_take) begin
      rsp_valid  <= skid_valid || new_valid;
      skid_valid <= 1'b0;
    end else if (new_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rsp_valid || rsp_take) begin
      rsp_data <= skid_valid ? skid_rsp : new_rsp;
    end else if (new_valid) begin
      skid_rsp <= new_rsp;
    end
  end

endmodule

`default_nettype wire
